>>> sv/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and constants of the stack machine execute unit
// opcodes, status codes, widths and the arithmetic unit interface structs
// ----------------------------------------------------------------------------
`default_nettype none
package smeu_pkg;

  localparam int unsigned StackDepth = 512;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned WordW      = 32;
  localparam int unsigned DepthW     = 10;

  typedef enum logic [3:0] {
    OpPush = 4'd0, OpAdd = 4'd1, OpSub = 4'd2, OpMul = 4'd3, OpDiv = 4'd4,
    OpMod  = 4'd5, OpDup = 4'd6, OpSwap = 4'd7, OpOver = 4'd8, OpPop = 4'd9,
    OpHalt = 4'd10, OpEq = 4'd11, OpLt = 4'd12, OpGt = 4'd13
  } opcode_e;

  typedef enum logic [2:0] {
    StRun = 3'd0, StHalt = 3'd1, StOver = 3'd2, StUnder = 3'd3,
    StDivZ = 3'd4, StBad = 3'd5
  } status_e;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic             start;
    logic [3:0]       op;
    logic [WordW-1:0] sec;
    logic [WordW-1:0] top;
  } alu_req_t;

  // response of the shared arithmetic unit
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

>>> sv/smeu_alu.sv
// ----------------------------------------------------------------------------
// smeu_alu: shared arithmetic unit
// add, sub and compares straight from idle; mul (2 bits a step);
// restoring division on magnitudes with sign fix-up
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_alu
  import smeu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  alu_req_t      req_i,
  output alu_rsp_t      rsp_o
);

  typedef enum logic [3:0] {
    SIdle = 4'b0001, SMul = 4'b0010, SDiv = 4'b0100, SFix = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [3:0]       op_q, op_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [WordW-1:0] a_q, a_d;       // multiplicand / quotient shifter
  logic [WordW-1:0] b_q, b_d;       // multiplier / divisor magnitude
  logic [WordW-1:0] acc_q, acc_d;   // product / partial remainder
  logic             sa_q, sa_d, sb_q, sb_d;
  logic             done_q, done_d;
  logic [WordW-1:0] res_q, res_d;
  logic [WordW:0]   trial;
  logic [WordW-1:0] mag_s, mag_t, quo, rem;

  always_comb begin
    mag_s = req_i.sec[WordW-1] ? (~req_i.sec + 1'b1) : req_i.sec;
    mag_t = req_i.top[WordW-1] ? (~req_i.top + 1'b1) : req_i.top;
    trial = {acc_q, a_q[WordW-1]} - {1'b0, b_q};
    quo   = (sa_q ^ sb_q) ? (~a_q + 1'b1) : a_q;
    rem   = sa_q ? (~acc_q + 1'b1) : acc_q;
  end

  always_comb begin
    state_d = state_q; op_d = op_q; cnt_d = cnt_q;
    a_d = a_q; b_d = b_q; acc_d = acc_q; sa_d = sa_q; sb_d = sb_q;
    done_d = 1'b0; res_d = res_q;
    unique case (state_q)
      SIdle: begin
        if (req_i.start) begin
          op_d = req_i.op;
          priority case (req_i.op)
            OpAdd: begin res_d = req_i.sec + req_i.top; done_d = 1'b1; end
            OpSub: begin res_d = req_i.sec - req_i.top; done_d = 1'b1; end
            OpEq: begin
              res_d = {{(WordW-1){1'b0}}, req_i.sec == req_i.top}; done_d = 1'b1;
            end
            OpLt: begin
              res_d = {{(WordW-1){1'b0}}, $signed(req_i.sec) < $signed(req_i.top)};
              done_d = 1'b1;
            end
            OpGt: begin
              res_d = {{(WordW-1){1'b0}}, $signed(req_i.sec) > $signed(req_i.top)};
              done_d = 1'b1;
            end
            OpMul: begin
              a_d = req_i.sec; b_d = req_i.top; acc_d = '0; cnt_d = 6'd16;
              state_d = SMul;
            end
            default: begin
              a_d = mag_s; b_d = mag_t; acc_d = '0; cnt_d = 6'd32;
              sa_d = req_i.sec[WordW-1]; sb_d = req_i.top[WordW-1];
              state_d = SDiv;
            end
          endcase
        end
      end
      SMul: begin
        // two multiplier bits per step, low bits first
        acc_d = acc_q + (b_q[0] ? a_q : '0) + (b_q[1] ? {a_q[WordW-2:0], 1'b0} : '0);
        a_d   = {a_q[WordW-3:0], 2'b00};
        b_d   = {2'b00, b_q[WordW-1:2]};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          res_d = acc_d; done_d = 1'b1; state_d = SIdle;
        end
      end
      SDiv: begin
        if (!trial[WordW]) begin
          acc_d = trial[WordW-1:0];
          a_d   = {a_q[WordW-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[WordW-2:0], a_q[WordW-1]};
          a_d   = {a_q[WordW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = SFix;
      end
      SFix: begin
        res_d = (op_q == OpDiv) ? quo : rem;
        done_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; cnt_q <= cnt_d; a_q <= a_d; b_q <= b_d; acc_q <= acc_d;
    sa_q <= sa_d; sb_q <= sb_d; res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule
`default_nettype wire

>>> sv/smeu_stack_ram.sv
// ----------------------------------------------------------------------------
// smeu_stack_ram: word stack storage
// one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_stack_ram
  import smeu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WordW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem_q [StackDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit: one stack-machine instruction per item
// sequencer around a stack memory and a shared multi-cycle arithmetic unit
// ----------------------------------------------------------------------------
// usage
//   input channel carries mode_i (opcode) and immediate_i (push value);
//   output channel carries one result item per input item: popped word,
//   status and stack depth after the instruction
//   the block takes one item at a time; in_ready_o is low while it works
//   push, halt and stopped items go from decode straight to output; dup
//   and pop read the top; over, swap and arithmetic read two words, swap
//   adds a second write; arithmetic waits on the restoring divider (one
//   quotient bit a cycle) or two-bit-a-step multiplier of the shared unit
//   stack reads go through one registered memory read port, one per cycle
//   the result sits in an output register; a stalled receiver holds it and
//   the next item is taken once it is gone
//   reset empties the stack (count only, memory is not cleared) and
//   clears the stop cause; a halt or an error stops execution until reset,
//   later items report the stop cause and leave the stack alone
// ----------------------------------------------------------------------------
`default_nettype none
module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         mode_i,
  input  wire logic signed [31:0] immediate_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    popped_valid_o,
  output logic signed [31:0]      popped_value_o,
  output logic [2:0]              status_o,
  output logic [9:0]              depth_o
);

  // sequencer states
  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,  // wait for an item
    SDec   = 9'b000000010,  // check and issue first read
    SRd1   = 9'b000000100,  // top read in flight
    SRd2   = 9'b000001000,  // capture top, issue second read
    SCap2  = 9'b000010000,  // capture second
    SAlu   = 9'b000100000,  // wait for arithmetic unit
    SWb    = 9'b001000000,  // second write of swap
    SOut   = 9'b010000000,  // present result
    SDummy = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        op_q, op_d;
  logic [WordW-1:0]  imm_q, imm_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [2:0]        stop_q, stop_d;
  logic [WordW-1:0]  top_q, top_d, sec_q, sec_d;
  logic              pv_q, pv_d;
  logic [WordW-1:0]  pval_q, pval_d;
  logic              alu_busy_q, alu_busy_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [WordW-1:0]  wdata, rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [1:0]        need;

  smeu_stack_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  smeu_alu u_alu (.clk_i, .rst_ni, .req_i(alu_req), .rsp_o(alu_rsp));

  // operands that each opcode needs on the stack
  always_comb begin
    unique case (op_q)
      OpPush, OpHalt: need = 2'd0;
      OpDup, OpPop:   need = 2'd1;
      default:        need = 2'd2;
    endcase
  end

  // set once the arithmetic unit has been started for this item
  assign alu_busy_d = (state_q == SAlu);

  always_comb begin
    state_d = state_q; op_d = op_q; imm_d = imm_q; cnt_d = cnt_q;
    stop_d = stop_q; top_d = top_q; sec_d = sec_q; pv_d = pv_q; pval_d = pval_q;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = AddrW'(cnt_q - CountW'(1));
    alu_req = '0;
    alu_req.op = op_q; alu_req.sec = sec_q; alu_req.top = top_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          op_d = mode_i; imm_d = immediate_i; pv_d = 1'b0; pval_d = '0;
          state_d = SDec;
        end
      end
      SDec: begin
        state_d = SOut;
        if (stop_q == StRun) begin
          priority if (op_q > OpGt) begin
            stop_d = StBad;
          end else if (cnt_q < CountW'(need)) begin
            stop_d = StUnder;
          end else if ((op_q == OpPush || op_q == OpDup || op_q == OpOver)
                       && cnt_q >= CountW'(StackDepth)) begin
            stop_d = StOver;
          end else if (op_q == OpHalt) begin
            stop_d = StHalt;
          end else if (op_q == OpPush) begin
            we = 1'b1; waddr = AddrW'(cnt_q); wdata = imm_q;
            cnt_d = cnt_q + CountW'(1);
          end else begin
            state_d = SRd1;   // read of top issued here
          end
        end
      end
      SRd1: begin
        state_d = SRd2;
      end
      SRd2: begin
        top_d = rdata;
        raddr = AddrW'(cnt_q - CountW'(2));
        priority case (op_q)
          OpDup: begin
            we = 1'b1; waddr = AddrW'(cnt_q); wdata = rdata;
            cnt_d = cnt_q + CountW'(1); state_d = SOut;
          end
          OpPop: begin
            pv_d = 1'b1; pval_d = rdata; cnt_d = cnt_q - CountW'(1);
            state_d = SOut;
          end
          default: state_d = SCap2;
        endcase
      end
      SCap2: begin
        sec_d = rdata;
        priority case (op_q)
          OpOver: begin
            we = 1'b1; waddr = AddrW'(cnt_q); wdata = rdata;
            cnt_d = cnt_q + CountW'(1); state_d = SOut;
          end
          OpSwap: begin
            we = 1'b1; waddr = AddrW'(cnt_q - CountW'(1)); wdata = rdata;
            state_d = SWb;
          end
          default: begin
            if ((op_q == OpDiv || op_q == OpMod) && top_q == '0) begin
              stop_d = StDivZ; state_d = SOut;
            end else begin
              state_d = SAlu;
            end
          end
        endcase
      end
      SAlu: begin
        // start pulses on the first cycle only
        alu_req.start = !alu_busy_q;
        if (alu_rsp.done) begin
          we = 1'b1; waddr = AddrW'(cnt_q - CountW'(2)); wdata = alu_rsp.result;
          cnt_d = cnt_q - CountW'(1); state_d = SOut;
        end
      end
      SWb: begin
        we = 1'b1; waddr = AddrW'(cnt_q - CountW'(2)); wdata = top_q;
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      cnt_q      <= '0;
      stop_q     <= StRun;
      alu_busy_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      stop_q     <= stop_d;
      alu_busy_q <= alu_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; imm_q <= imm_d; top_q <= top_d; sec_q <= sec_d;
    pv_q <= pv_d; pval_q <= pval_d;
  end

  assign in_ready_o     = (state_q == SIdle);
  assign out_valid_o    = (state_q == SOut);
  assign popped_valid_o = pv_q;
  assign popped_value_o = pval_q;
  assign status_o       = stop_q;
  assign depth_o        = DepthW'(cnt_q);

endmodule
`default_nettype wire

>>> sv/smeu_checker.sv
// ----------------------------------------------------------------------------
// smeu_checker: port-level checks of the execute unit
// stop status sticks, depth bounds and one-at-a-time handshake
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_checker
  import smeu_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        popped_valid_o,
  input wire logic [31:0] popped_value_o,
  input wire logic [2:0]  status_o,
  input wire logic [9:0]  depth_o
);

  // never ready for input while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  // a pop result is never a stopping result, other results carry a zero word
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (popped_valid_o ? (status_o == StRun) : (popped_value_o == '0)))
    else $error("bad popped word or status");

  // once stopped, status and depth stay
  a_stick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && status_o != StRun |=> $stable(status_o) && $stable(depth_o))
    else $error("stop status changed");

  // depth never exceeds the stack size
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_o <= 10'(StackDepth)) else $error("depth out of range");

  // busy right after an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accepted item");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (.*);
`default_nettype wire
